[hdl/qrs_pkg.sv]
`timescale 1ns / 1ps

package qrs_pkg;

  // Field and datapath widths.
  localparam int COEF_W   = 32;             // coefficient width (Q16.16 by default)
  localparam int DISC_W   = 66;             // discriminant magnitude width
  localparam int ROOT_W   = 33;             // integer square root width
  localparam int SQREM_W  = 67;             // square root remainder width
  localparam int NUM_W    = 35;             // signed numerator width
  localparam int DIVR_W   = 33;             // divisor width (2 * |a|)
  localparam int LIM_W    = 16;             // coefficient zero limit width
  localparam int DLIM_W   = 32;             // discriminant limit width
  localparam int STAT_W   = 3;
  localparam int SQ_CELLS = ROOT_W;         // one cell per root bit

  // Register map (index taken from paddr[2]).
  localparam logic REG_COEF_LIM = 1'b0;
  localparam logic REG_DISC_LIM = 1'b1;

  localparam logic [LIM_W-1:0]  COEF_LIM_RST = 16'd1;
  localparam logic [DLIM_W-1:0] DISC_LIM_RST = 32'd429;

  typedef enum logic [STAT_W-1:0] {
    ST_INFINITE  = 3'd0,
    ST_NOT_QUAD  = 3'd1,
    ST_NO_ROOTS  = 3'd2,
    ST_ONE_ROOT  = 3'd3,
    ST_TWO_ROOTS = 3'd4
  } qrs_status_e;

  // Side data carried along the square root chain.
  typedef struct packed {
    qrs_status_e              status;
    logic                     a_neg;
    logic [COEF_W-1:0]        mag_a;
    logic signed [COEF_W-1:0] coef_b;
  } qrs_sside_t;

  // Side data carried along the divider chain.
  typedef struct packed {
    qrs_status_e status;
    logic        neg_p;
    logic        neg_m;
  } qrs_dside_t;

endpackage

[hdl/qrs_sqrt_cell.sv]
`timescale 1ns / 1ps

// One bit of the integer square root: tries to set root bit BIT.
module qrs_sqrt_cell import qrs_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [SQREM_W-1:0] rem_i,
  input  logic [ROOT_W-1:0]  root_i,
  input  qrs_sside_t         side_i,
  output logic               vld_o,
  output logic [SQREM_W-1:0] rem_o,
  output logic [ROOT_W-1:0]  root_o,
  output qrs_sside_t         side_o
);

  logic [SQREM_W-1:0] trial;
  logic               fits;
  logic [SQREM_W-1:0] rem_d, rem_q;
  logic [ROOT_W-1:0]  root_d, root_q;
  logic               vld_q;
  qrs_sside_t         side_q;

  // (r + 2^BIT)^2 - r^2 = r * 2^(BIT+1) + 2^(2*BIT).
  assign trial  = (SQREM_W'(root_i) << (BIT + 1)) | (SQREM_W'(1) << (2 * BIT));
  assign fits   = (rem_i >= trial);
  assign rem_d  = fits ? (rem_i - trial) : rem_i;
  assign root_d = fits ? (root_i | (ROOT_W'(1) << BIT)) : root_i;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign side_o = side_q;

endmodule

[hdl/qrs_div_cell.sv]
`timescale 1ns / 1ps

// One restoring division step for both root lanes. The dividend shifts out
// at the top of x while quotient bits shift in at the bottom.
module qrs_div_cell import qrs_pkg::*; #(
  parameter int NW = 51
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [DIVR_W-1:0] dv_i,
  input  logic [DIVR_W-1:0] rem_p_i,
  input  logic [NW-1:0]     x_p_i,
  input  logic [DIVR_W-1:0] rem_m_i,
  input  logic [NW-1:0]     x_m_i,
  input  qrs_dside_t        side_i,
  output logic              vld_o,
  output logic [DIVR_W-1:0] dv_o,
  output logic [DIVR_W-1:0] rem_p_o,
  output logic [NW-1:0]     x_p_o,
  output logic [DIVR_W-1:0] rem_m_o,
  output logic [NW-1:0]     x_m_o,
  output qrs_dside_t        side_o
);

  logic [DIVR_W:0]   t_p, t_m, dv_ext;
  logic              ge_p, ge_m;
  logic [DIVR_W-1:0] rem_p_q, rem_m_q, dv_q;
  logic [NW-1:0]     x_p_q, x_m_q;
  logic              vld_q;
  qrs_dside_t        side_q;

  assign dv_ext = {1'b0, dv_i};
  assign t_p    = {rem_p_i, x_p_i[NW-1]};
  assign t_m    = {rem_m_i, x_m_i[NW-1]};
  assign ge_p   = (t_p >= dv_ext);
  assign ge_m   = (t_m >= dv_ext);

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // Payload: conditional subtract and quotient bit shift.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_p_q <= ge_p ? DIVR_W'(t_p - dv_ext) : t_p[DIVR_W-1:0];
      rem_m_q <= ge_m ? DIVR_W'(t_m - dv_ext) : t_m[DIVR_W-1:0];
      x_p_q   <= {x_p_i[NW-2:0], ge_p};
      x_m_q   <= {x_m_i[NW-2:0], ge_m};
      dv_q    <= dv_i;
      side_q  <= side_i;
    end
  end

  assign vld_o   = vld_q;
  assign dv_o    = dv_q;
  assign rem_p_o = rem_p_q;
  assign x_p_o   = x_p_q;
  assign rem_m_o = rem_m_q;
  assign x_m_o   = x_m_q;
  assign side_o  = side_q;

endmodule

[hdl/quadratic_root_solver.sv]
`timescale 1ns / 1ps

// Quadratic root solver for a*x^2 + b*x + c = 0 in signed fixed point.
// Input stream: one item carries a, b and c (32-bit signed, FRAC_BITS
// fraction bits). Output stream: one item per input with the two roots in
// tdata and the status code and saturation flag in tuser.
// The datapath is a single pipeline: input register, product stage,
// discriminant stage, 33 square root cells (one root bit each), a numerator
// stage, 35 + FRAC_BITS divider cells (one quotient bit each, both roots in
// parallel) and the output register. Throughput is one item per cycle while
// the receiver does not stall.
// When the receiver stalls with a result held in the output register, the
// whole pipeline holds and s_axis_tready drops until the result is taken.
// Reset empties the pipeline and sets coef_zero_limit to 1 and
// disc_zero_limit to 429. Registers are written over the APB port at byte
// addresses 0 and 4 and should only change while the pipeline is empty.
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // coef_quad, coef_lin, coef_const
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // root_plus, root_minus
  output logic [3:0]  m_axis_tuser,   // root_status, root_saturated
  // Configuration.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NW = NUM_W + FRAC_BITS;   // dividend and quotient width

  logic adv;

  // Configuration registers.
  logic [LIM_W-1:0]  coef_lim_q;
  logic [DLIM_W-1:0] disc_lim_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_lim_q <= COEF_LIM_RST;
      disc_lim_q <= DISC_LIM_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_COEF_LIM) begin
        coef_lim_q <= pwdata[LIM_W-1:0];
      end else begin
        disc_lim_q <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == REG_COEF_LIM) ? {16'd0, coef_lim_q} : disc_lim_q;

  // The pipeline moves whenever the output register is free or being taken.
  logic m_vld_q;
  assign adv           = !m_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  // Stage 1: magnitudes and near-zero tests.
  logic signed [COEF_W-1:0] in_a, in_b, in_c;
  logic [COEF_W-1:0]        in_ma, in_mb, in_mc;
  logic [LIM_W-1:0]         eff_lim;
  logic                     nz_a, nz_b, nz_c;

  assign in_a    = s_axis_tdata[31:0];
  assign in_b    = s_axis_tdata[63:32];
  assign in_c    = s_axis_tdata[95:64];
  assign in_ma   = in_a[COEF_W-1] ? COEF_W'(-in_a) : in_a;
  assign in_mb   = in_b[COEF_W-1] ? COEF_W'(-in_b) : in_b;
  assign in_mc   = in_c[COEF_W-1] ? COEF_W'(-in_c) : in_c;
  assign eff_lim = (coef_lim_q == '0) ? LIM_W'(1) : coef_lim_q;
  assign nz_a    = (in_ma < COEF_W'(eff_lim));
  assign nz_b    = (in_mb < COEF_W'(eff_lim));
  assign nz_c    = (in_mc < COEF_W'(eff_lim));

  logic                     s1_vld_q, s1_quad_q, s1_sdiff_q;
  logic [COEF_W-1:0]        s1_mb_q, s1_mc_q;
  qrs_sside_t               s1_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_quad_q        <= !nz_a;
      s1_sdiff_q       <= in_a[COEF_W-1] != in_c[COEF_W-1];
      s1_mb_q          <= in_mb;
      s1_mc_q          <= in_mc;
      s1_side_q.status <= (nz_b && nz_c) ? ST_INFINITE : ST_NOT_QUAD;
      s1_side_q.a_neg  <= in_a[COEF_W-1];
      s1_side_q.mag_a  <= in_ma;
      s1_side_q.coef_b <= in_b;
    end
  end

  // Stage 2: b*b and a*c.
  logic                    s2_vld_q, s2_quad_q, s2_sdiff_q;
  logic [2*COEF_W-1:0]     s2_bb_q, s2_ac_q;
  qrs_sside_t              s2_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_bb_q    <= s1_mb_q * s1_mb_q;
      s2_ac_q    <= s1_side_q.mag_a * s1_mc_q;
      s2_quad_q  <= s1_quad_q;
      s2_sdiff_q <= s1_sdiff_q;
      s2_side_q  <= s1_side_q;
    end
  end

  // Stage 3: discriminant magnitude and sign.
  logic [DISC_W-1:0] bb_ext, f4ac;
  logic [DISC_W-1:0] d_mag_d;
  logic              d_neg_d;

  assign bb_ext = DISC_W'(s2_bb_q);
  assign f4ac   = {s2_ac_q, 2'b00};

  always_comb begin
    if (s2_sdiff_q) begin
      d_mag_d = bb_ext + f4ac;
      d_neg_d = 1'b0;
    end else if (f4ac <= bb_ext) begin
      d_mag_d = bb_ext - f4ac;
      d_neg_d = 1'b0;
    end else begin
      d_mag_d = f4ac - bb_ext;
      d_neg_d = 1'b1;
    end
  end

  logic              s3_vld_q, s3_quad_q, s3_neg_q;
  logic [DISC_W-1:0] s3_d_q;
  qrs_sside_t        s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_d_q    <= d_mag_d;
      s3_neg_q  <= d_neg_d;
      s3_quad_q <= s2_quad_q;
      s3_side_q <= s2_side_q;
    end
  end

  // Classify the discriminant on entry to the square root chain.
  logic       d_big;
  qrs_sside_t sq_side0;

  assign d_big = (s3_d_q > DISC_W'(disc_lim_q));

  always_comb begin
    sq_side0 = s3_side_q;
    if (s3_quad_q) begin
      if (s3_neg_q && d_big) begin
        sq_side0.status = ST_NO_ROOTS;
      end else if (!d_big) begin
        sq_side0.status = ST_ONE_ROOT;
      end else begin
        sq_side0.status = ST_TWO_ROOTS;
      end
    end
  end

  // Square root chain.
  logic               sq_vld  [SQ_CELLS+1];
  logic [SQREM_W-1:0] sq_rem  [SQ_CELLS+1];
  logic [ROOT_W-1:0]  sq_root [SQ_CELLS+1];
  qrs_sside_t         sq_side [SQ_CELLS+1];

  assign sq_vld[0]  = s3_vld_q;
  assign sq_rem[0]  = SQREM_W'(s3_d_q);
  assign sq_root[0] = '0;
  assign sq_side[0] = sq_side0;

  for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
    qrs_sqrt_cell #(
      .BIT(SQ_CELLS - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (sq_vld[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .side_i (sq_side[k]),
      .vld_o  (sq_vld[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .side_o (sq_side[k+1])
    );
  end

  // Numerator stage: -b +- sqrt(D), magnitudes and dividends.
  qrs_sside_t              sq_out;
  logic [ROOT_W-1:0]       s_use;
  logic signed [NUM_W-1:0] neg_b, num_p, num_m;
  logic [NUM_W-1:0]        nm_p, nm_m;
  qrs_dside_t              dv_side0;

  assign sq_out = sq_side[SQ_CELLS];
  assign s_use  = (sq_out.status == ST_TWO_ROOTS) ? sq_root[SQ_CELLS] : '0;
  assign neg_b  = -NUM_W'(sq_out.coef_b);
  assign num_p  = neg_b + $signed(NUM_W'(s_use));
  assign num_m  = neg_b - $signed(NUM_W'(s_use));
  assign nm_p   = num_p[NUM_W-1] ? NUM_W'(-num_p) : num_p;
  assign nm_m   = num_m[NUM_W-1] ? NUM_W'(-num_m) : num_m;

  assign dv_side0.status = sq_out.status;
  assign dv_side0.neg_p  = num_p[NUM_W-1] ^ sq_out.a_neg;
  assign dv_side0.neg_m  = num_m[NUM_W-1] ^ sq_out.a_neg;

  logic              nu_vld_q;
  logic [DIVR_W-1:0] nu_dv_q;
  logic [NW-1:0]     nu_x_p_q, nu_x_m_q;
  qrs_dside_t        nu_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nu_vld_q <= 1'b0;
    end else if (adv) begin
      nu_vld_q <= sq_vld[SQ_CELLS];
    end
  end

  // Dividend is |n| * 2^F + |a| so that the floor quotient rounds to nearest.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      nu_dv_q   <= {sq_out.mag_a, 1'b0};
      nu_x_p_q  <= (NW'(nm_p) << FRAC_BITS) + NW'(sq_out.mag_a);
      nu_x_m_q  <= (NW'(nm_m) << FRAC_BITS) + NW'(sq_out.mag_a);
      nu_side_q <= dv_side0;
    end
  end

  // Divider chain.
  logic              dc_vld  [NW+1];
  logic [DIVR_W-1:0] dc_dv   [NW+1];
  logic [DIVR_W-1:0] dc_rp   [NW+1];
  logic [NW-1:0]     dc_xp   [NW+1];
  logic [DIVR_W-1:0] dc_rm   [NW+1];
  logic [NW-1:0]     dc_xm   [NW+1];
  qrs_dside_t        dc_side [NW+1];

  assign dc_vld[0]  = nu_vld_q;
  assign dc_dv[0]   = nu_dv_q;
  assign dc_rp[0]   = '0;
  assign dc_xp[0]   = nu_x_p_q;
  assign dc_rm[0]   = '0;
  assign dc_xm[0]   = nu_x_m_q;
  assign dc_side[0] = nu_side_q;

  for (genvar k = 0; k < NW; k++) begin : g_div
    qrs_div_cell #(
      .NW(NW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .vld_i   (dc_vld[k]),
      .dv_i    (dc_dv[k]),
      .rem_p_i (dc_rp[k]),
      .x_p_i   (dc_xp[k]),
      .rem_m_i (dc_rm[k]),
      .x_m_i   (dc_xm[k]),
      .side_i  (dc_side[k]),
      .vld_o   (dc_vld[k+1]),
      .dv_o    (dc_dv[k+1]),
      .rem_p_o (dc_rp[k+1]),
      .x_p_o   (dc_xp[k+1]),
      .rem_m_o (dc_rm[k+1]),
      .x_m_o   (dc_xm[k+1]),
      .side_o  (dc_side[k+1])
    );
  end

  // Saturate both quotients to the signed 32-bit range.
  logic [NW-1:0]     q_p, q_m;
  logic              sat_p, sat_m;
  logic [COEF_W-1:0] r_p, r_m;
  qrs_dside_t        dc_out;

  assign q_p    = dc_xp[NW];
  assign q_m    = dc_xm[NW];
  assign dc_out = dc_side[NW];

  always_comb begin
    if (dc_out.neg_p) begin
      sat_p = (q_p > NW'(33'h0_8000_0000));
      r_p   = sat_p ? 32'h8000_0000 : COEF_W'(-q_p[COEF_W-1:0]);
    end else begin
      sat_p = (q_p > NW'(33'h0_7FFF_FFFF));
      r_p   = sat_p ? 32'h7FFF_FFFF : q_p[COEF_W-1:0];
    end
    if (dc_out.neg_m) begin
      sat_m = (q_m > NW'(33'h0_8000_0000));
      r_m   = sat_m ? 32'h8000_0000 : COEF_W'(-q_m[COEF_W-1:0]);
    end else begin
      sat_m = (q_m > NW'(33'h0_7FFF_FFFF));
      r_m   = sat_m ? 32'h7FFF_FFFF : q_m[COEF_W-1:0];
    end
  end

  // Output register.
  logic [STAT_W-1:0] o_status_q;
  logic [COEF_W-1:0] o_plus_q, o_minus_q;
  logic              o_sat_q;
  logic              use_p, use_m;

  assign use_p = (dc_out.status == ST_ONE_ROOT) || (dc_out.status == ST_TWO_ROOTS);
  assign use_m = (dc_out.status == ST_TWO_ROOTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (adv) begin
      m_vld_q <= dc_vld[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_status_q <= dc_out.status;
      o_plus_q   <= use_p ? r_p : '0;
      o_minus_q  <= use_m ? r_m : '0;
      o_sat_q    <= (use_p && sat_p) || (use_m && sat_m);
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {o_minus_q, o_plus_q};
  assign m_axis_tuser  = {o_sat_q, o_status_q};

  // Only the two-root case fills the minus root.
  a_minus_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_vld_q && o_status_q != ST_TWO_ROOTS) |-> (o_minus_q == '0))
    else $error("minus root set without two roots");

  // Without a root there is neither a value nor a saturation.
  a_no_root_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_vld_q && (o_status_q == ST_INFINITE || o_status_q == ST_NOT_QUAD ||
                 o_status_q == ST_NO_ROOTS)) |-> (o_plus_q == '0 && !o_sat_q))
    else $error("root data present for a rootless status");

  // A saturated result holds at least one clipped extreme.
  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_vld_q && o_sat_q) |->
      (o_plus_q == 32'h7FFF_FFFF || o_plus_q == 32'h8000_0000 ||
       o_minus_q == 32'h7FFF_FFFF || o_minus_q == 32'h8000_0000))
    else $error("saturation flag without a clipped root");

endmodule

[tb/quadratic_root_solver_tb.sv]
`timescale 1ns / 1ps

module quadratic_root_solver_tb import qrs_pkg::*; ();

  localparam int FRAC = 16;
  localparam int DRAIN_CYCLES = 200;

  // Register byte addresses.
  localparam logic [2:0] ADDR_COEF_LIM = 3'd0;
  localparam logic [2:0] ADDR_DISC_LIM = 3'd4;

  typedef struct packed {
    qrs_status_e status;
    logic [31:0] rplus;
    logic [31:0] rminus;
    logic        sat;
  } roots_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Local copy of the limit registers.
  logic [15:0] coef_lim_q;
  logic [31:0] disc_lim_q;

  roots_t      roots_expected[$];
  int          failures = 0;
  bit          rx_stall_heavy = 1'b0;

  quadratic_root_solver dut (.*);

  always #1 clk_i = ~clk_i;

  // Rounded root: num * 2^FRAC / (2|a|), saturated to 32 bits.
  function automatic logic [31:0] solve_div(input logic signed [67:0] num,
                                            input logic [31:0] ma, input bit aneg,
                                            inout bit sat);
    logic [67:0] nm;
    logic [99:0] q;
    bit          neg;
    nm  = num < 0 ? -num : num;
    q   = (({32'd0, nm} << FRAC) + ma) / ({68'd0, ma} * 2);
    neg = (num < 0) != aneg;
    if (neg) begin
      if (q > 100'h80000000) begin
        q = 100'h80000000;
        sat = 1'b1;
      end
      return -q[31:0];
    end
    if (q > 100'h7FFFFFFF) begin
      q = 100'h7FFFFFFF;
      sat = 1'b1;
    end
    return q[31:0];
  endfunction

  function automatic logic [32:0] floor_sqrt(input logic [67:0] d);
    logic [32:0] r;
    logic [32:0] t;
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      t = r | (33'd1 << b);
      if ({35'd0, t} * {35'd0, t} <= {32'd0, d}) r = t;
    end
    return r;
  endfunction

  function automatic roots_t solve_quadratic(input logic [31:0] a, b, c);
    roots_t             r;
    logic signed [67:0] sa, sb, sc, disc, s;
    logic [31:0]        ma, mb, mc;
    logic [16:0]        lim;
    bit                 sat;
    r   = '{ST_INFINITE, 32'd0, 32'd0, 1'b0};
    sat = 1'b0;
    sa  = $signed(a);
    sb  = $signed(b);
    sc  = $signed(c);
    ma  = sa < 0 ? -sa[31:0] : sa[31:0];
    mb  = sb < 0 ? -sb[31:0] : sb[31:0];
    mc  = sc < 0 ? -sc[31:0] : sc[31:0];
    lim = coef_lim_q == 0 ? 17'd1 : {1'b0, coef_lim_q};
    if (ma < lim) begin
      r.status = (mb < lim && mc < lim) ? ST_INFINITE : ST_NOT_QUAD;
      return r;
    end
    disc = sb * sb - 4 * sa * sc;
    if (disc < -$signed({36'd0, disc_lim_q})) begin
      r.status = ST_NO_ROOTS;
    end else if (disc <= $signed({36'd0, disc_lim_q})) begin
      r.status = ST_ONE_ROOT;
      r.rplus  = solve_div(-sb, ma, a[31], sat);
    end else begin
      s        = $signed({35'd0, floor_sqrt(disc)});
      r.status = ST_TWO_ROOTS;
      r.rplus  = solve_div(-sb + s, ma, a[31], sat);
      r.rminus = solve_div(-sb - s, ma, a[31], sat);
    end
    r.sat = sat;
    return r;
  endfunction

  // Register write: setup cycle then access cycle.
  task automatic write_limit(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk_i);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= addr;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_COEF_LIM) coef_lim_q = value[15:0];
    else disc_lim_q = value;
  endtask

  // Send one equation; the expectation is queued once it is accepted.
  task automatic send_equation(input logic [31:0] a, b, c);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c, b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    roots_expected.push_back(solve_quadratic(a, b, c));
    @(negedge clk_i);
  endtask

  task automatic idle_sender();
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk_i);
  endtask

  // Wait for every result, then let the pipeline settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (roots_expected.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 8) - 4;
      2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
      3: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
      4: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(0, 40)) - 20) <<< 16;
    endcase
  endfunction

  task automatic test_directed();
    // Infinite and not quadratic.
    send_equation(32'd0, 32'd0, 32'd0);
    send_equation(32'd0, 32'h0001_0000, 32'd0);
    send_equation(32'd0, 32'd0, 32'h8000_0000);
    // x^2 - 3x + 2: two roots; x^2 - 2x + 1: double root; x^2 + 1: none.
    send_equation(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000);
    send_equation(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000);
    send_equation(32'h0001_0000, 32'd0, 32'h0001_0000);
    send_equation(32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000);
    // Extremes and saturation.
    send_equation(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_equation(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_equation(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_equation(32'd1, 32'h7FFF_FFFF, 32'd0);
    send_equation(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_equation(32'd1, 32'd0, 32'hFFFF_FFFF);
    send_equation(32'd1, 32'd2, 32'd1);
    send_equation(32'hFFFF_FFFF, 32'd0, 32'd0);
    drain();
  endtask

  task automatic test_random(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      repeat ($urandom_range(1, 20)) begin
        if (sent < count) begin
          send_equation(rand_coef(), rand_coef(), rand_coef());
          sent++;
        end
      end
      if ($urandom_range(0, 2) != 0) idle_sender();
    end
    drain();
  endtask

  // Limit extremes, including a zero coefficient limit.
  task automatic test_limits();
    write_limit(ADDR_COEF_LIM, 32'd0);
    write_limit(ADDR_DISC_LIM, 32'd0);
    test_random(60);
    write_limit(ADDR_COEF_LIM, 32'd65535);
    write_limit(ADDR_DISC_LIM, 32'hFFFF_FFFF);
    test_directed();
    test_random(60);
    write_limit(ADDR_COEF_LIM, $urandom_range(0, 300));
    write_limit(ADDR_DISC_LIM, $urandom_range(0, 100000));
    rx_stall_heavy = 1'b1;
    test_random(60);
    rx_stall_heavy = 1'b0;
  endtask

  // Receiver stall pattern.
  always @(negedge clk_i) begin
    if (rx_stall_heavy) m_axis_tready <= ($urandom_range(0, 3) == 0);
    else m_axis_tready <= ($urandom_range(0, 15) < 12) || ($urandom_range(0, 1) == 1);
  end

  // Result checker.
  always @(posedge clk_i) begin
    roots_t got;
    roots_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = qrs_status_e'(m_axis_tuser[2:0]);
      got.rplus  = m_axis_tdata[31:0];
      got.rminus = m_axis_tdata[63:32];
      got.sat    = m_axis_tuser[3];
      if (roots_expected.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
        failures++;
      end else begin
        want = roots_expected.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, want.status, got.status);
          failures++;
        end
        if (got.rplus !== want.rplus) begin
          $display("%0t: root_plus expected %h actual %h", $realtime, want.rplus, got.rplus);
          failures++;
        end
        if (got.rminus !== want.rminus) begin
          $display("%0t: root_minus expected %h actual %h", $realtime, want.rminus,
                   got.rminus);
          failures++;
        end
        if (got.sat !== want.sat) begin
          $display("%0t: saturated expected %b actual %b", $realtime, want.sat, got.sat);
          failures++;
        end
      end
    end
  end

  initial begin
    coef_lim_q = COEF_LIM_RST;
    disc_lim_q = DISC_LIM_RST;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(300);
    test_limits();
    if (failures == 0 && roots_expected.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Run time limit.
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
hdl/qrs_pkg.sv
hdl/qrs_sqrt_cell.sv
hdl/qrs_div_cell.sv
hdl/quadratic_root_solver.sv
tb/quadratic_root_solver_tb.sv
